// File: hdl/lbw_pkg.sv
// lbw_pkg: shared types, constants and Q8.24 helpers for the Lagrange basis block.
// No dependencies.
package lbw_pkg;

    localparam int CFG_W = 5;    // nodes_in_use register width
    localparam int IDX_W = 4;    // node_index / weight_index width
    localparam int Q_W   = 32;   // Q8.24 word width

    localparam logic signed [Q_W-1:0] ONE_Q = 32'sh0100_0000;
    localparam logic signed [Q_W-1:0] Q_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [Q_W-1:0] Q_MIN = 32'sh8000_0000;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

    typedef logic signed [Q_W-1:0]   t_q;
    typedef logic signed [2*Q_W-1:0] t_prod;

    // a - b exact, saturated to 32 bits
    function automatic t_q diff_sat(input t_q a, input t_q b);
        logic signed [Q_W:0] d;
        begin
            d = {a[Q_W-1], a} - {b[Q_W-1], b};
            if (d > 33'sh0_7FFF_FFFF) begin
                diff_sat = Q_MAX;
            end else if (d < -33'sh0_8000_0000) begin
                diff_sat = Q_MIN;
            end else begin
                diff_sat = d[Q_W-1:0];
            end
        end
    endfunction

    // (p + 2^23) floor-shifted by 24, saturated
    function automatic t_q round_sat(input t_prod p);
        t_prod s;
        t_prod t;
        begin
            s = p + 64'sd8388608;
            t = s >>> 24;
            if (t > 64'sh0000_0000_7FFF_FFFF) begin
                round_sat = Q_MAX;
            end else if (t < -64'sh0000_0000_8000_0000) begin
                round_sat = Q_MIN;
            end else begin
                round_sat = t[Q_W-1:0];
            end
        end
    endfunction

endpackage

// File: hdl/lbw_if.sv
// lbw_if: valid/ready channel interfaces for input and result words.
// Depends on lbw_pkg.
interface lbw_in_if;
    logic                          valid;
    logic                          ready;
    logic                          command;
    logic [lbw_pkg::IDX_W-1:0]     node_index;
    logic signed [lbw_pkg::Q_W-1:0] value;

    modport source (output valid, command, node_index, value, input ready);
    modport sink   (input valid, command, node_index, value, output ready);
endinterface

interface lbw_out_if;
    logic                          valid;
    logic                          ready;
    logic signed [lbw_pkg::Q_W-1:0] weight;
    logic [lbw_pkg::IDX_W-1:0]     weight_index;
    logic                          last;
    logic                          zero_denominator;

    modport source (output valid, weight, weight_index, last, zero_denominator, input ready);
    modport sink   (input valid, weight, weight_index, last, zero_denominator, output ready);
endinterface

// File: hdl/lbw_ram.sv
// lbw_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module lbw_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: hdl/lbw_mul.sv
// lbw_mul: shared signed 32x32 multiplier with registered 64-bit product.
// Depends on lbw_pkg.
module lbw_mul (
    input  logic          i_clk,
    input  logic          i_en,
    input  lbw_pkg::t_q   i_a,
    input  lbw_pkg::t_q   i_b,
    output lbw_pkg::t_prod o_p
);
    import lbw_pkg::*;

    t_prod r_p;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= t_prod'(i_a) * t_prod'(i_b);
        end
    end

    assign o_p = r_p;
endmodule

// File: hdl/lbw_div.sv
// lbw_div: radix-2 restoring divider for 2^48 / d, truncated, saturated to Q8.24.
// Depends on lbw_pkg. 49 iterations; done pulses when the quotient is ready.
module lbw_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  lbw_pkg::t_q i_den,
    output logic        o_done,
    output lbw_pkg::t_q o_quot
);
    import lbw_pkg::*;

    localparam int QB = 49;

    logic          r_busy, n_busy;
    logic          r_done, n_done;
    logic [5:0]    r_cnt, n_cnt;
    logic [31:0]   r_rem, n_rem;
    logic [31:0]   r_dm, n_dm;
    logic [QB-1:0] r_q, n_q;
    logic          r_neg, n_neg;
    logic [32:0]   sh;

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_dm   = r_dm;
        n_q    = r_q;
        n_neg  = r_neg;
        sh     = {r_rem, (r_cnt == 6'd48)};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd48;
            n_rem  = '0;
            n_q    = '0;
            n_neg  = i_den[31];
            n_dm   = i_den[31] ? 32'(~i_den + 32'd1) : 32'(i_den);
        end else if (r_busy) begin
            if (sh >= {1'b0, r_dm}) begin
                n_rem = 32'(sh - {1'b0, r_dm});
                n_q   = {r_q[QB-2:0], 1'b1};
            end else begin
                n_rem = sh[31:0];
                n_q   = {r_q[QB-2:0], 1'b0};
            end
            if (r_cnt == 6'd0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 6'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_rem <= n_rem;
        r_dm  <= n_dm;
        r_q   <= n_q;
        r_neg <= n_neg;
    end

    always_comb begin
        if (r_neg) begin
            if (r_q > 49'h0_8000_0000) begin
                o_quot = Q_MIN;
            end else begin
                o_quot = 32'(~r_q + 49'd1);
            end
        end else begin
            if (r_q > 49'h0_7FFF_FFFF) begin
                o_quot = Q_MAX;
            end else begin
                o_quot = r_q[31:0];
            end
        end
    end

    assign o_done = r_done;
endmodule

// File: hdl/lagrange_basis_weights.sv
// lagrange_basis_weights: top level, sequencer around one shared multiplier
// and one iterative divider. Depends on lbw_pkg, lbw_if, lbw_ram, lbw_mul, lbw_div.
//
// Use:
//   i_word carries load words (command 0: node_index, value = node x in Q8.24)
//   and evaluate words (command 1: value = position p). A load produces nothing.
//   An evaluate produces one result word per node in use on o_word, ascending
//   node order, last set on the final node. nodes_in_use is written through
//   i_cfg_we / i_cfg_wdata; the user must write it only while idle, which the
//   block does not enforce. 0 acts as 1, values above MAX_NODES act as MAX_NODES.
// Sequence:
//   The first evaluate after a load or register write first rebuilds the
//   reciprocals: per node a product of differences on the shared multiplier,
//   then a divide (skipped when the denominator is zero).
//   Each weight then takes the product of (p - x_j), a multiply by the
//   reciprocal and a round, then the output handshake (a zero-denominator
//   node goes straight to the output handshake with weight 0).
//   The shared multiplier, each factor a multiply then a round, sets the pace.
// Reset: synchronous, active low; clears nodes_in_use to 1, the zero flags and
//   the reciprocal-valid flag. Node and reciprocal RAMs are not cleared.
// Stall: i_word.ready is low for the whole evaluate; a result waits in the
//   output register while o_word.ready is low, and the sequencer holds.
module lagrange_basis_weights #(
    parameter int MAX_NODES = 16
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    lbw_in_if.sink                      i_word,
    lbw_out_if.source                   o_word,
    input  logic                        i_cfg_we,
    input  logic [lbw_pkg::CFG_W-1:0]   i_cfg_wdata
);
    import lbw_pkg::*;

    localparam int IW = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CW = $clog2(MAX_NODES + 1) + 1;   // counters incl. n+1

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_RADI  = 14'b00000000000010,   // read node i
        S_RXI   = 14'b00000000000100,   // latch x_i, read first j
        S_RMUL  = 14'b00000000001000,
        S_RRND  = 14'b00000000010000,
        S_RDIV  = 14'b00000000100000,
        S_RWAIT = 14'b00000001000000,
        S_ESTA  = 14'b00000010000000,
        S_EMUL  = 14'b00000100000000,
        S_ERND  = 14'b00001000000000,
        S_ERCP  = 14'b00010000000000,   // read reciprocal i
        S_EWM   = 14'b00100000000000,
        S_EWR   = 14'b01000000000000,
        S_EOUT  = 14'b10000000000000
    } t_state;

    t_state             r_state, n_state;
    logic [CFG_W-1:0]   r_cfg;
    logic               r_rvalid, n_rvalid;
    logic [MAX_NODES-1:0] r_zflag, n_zflag;
    logic [CW-1:0]      r_i, n_i;
    logic [CW-1:0]      r_j, n_j;
    t_q                 r_acc, n_acc;
    t_q                 r_xi, n_xi;
    t_q                 r_pos, n_pos;
    t_q                 r_weight, n_weight;
    logic               r_zd, n_zd;

    logic [CW-1:0]      n_eff;
    logic [CW-1:0]      j_first, j_next, j_inc;
    logic [IW-1:0]      node_raddr;
    t_q                 node_rd, recip_rd;
    logic               node_we, recip_we;
    t_q                 recip_wdata;
    logic               mul_en;
    t_q                 mul_b;
    t_prod              mul_p;
    logic               div_start, div_done;
    t_q                 div_quot;
    logic               load_ok;

    // effective node count
    always_comb begin
        if (r_cfg == '0) begin
            n_eff = CW'(1);
        end else if (32'(r_cfg) > MAX_NODES) begin
            n_eff = CW'(MAX_NODES);
        end else begin
            n_eff = CW'(r_cfg);
        end
    end

    // inner index walks 0..n-1 skipping i
    assign j_first = (r_i == '0) ? CW'(1) : CW'(0);
    assign j_inc   = r_j + CW'(1);
    assign j_next  = (j_inc == r_i) ? (r_j + CW'(2)) : j_inc;

    assign load_ok = (32'(i_word.node_index) < MAX_NODES);
    assign node_we = (r_state == S_IDLE) && i_word.valid
                   && (i_word.command == CMD_LOAD) && load_ok;

    always_comb begin
        case (r_state)
            S_RADI:        node_raddr = r_i[IW-1:0];
            S_RXI, S_ESTA: node_raddr = j_first[IW-1:0];
            default:       node_raddr = j_next[IW-1:0];
        endcase
    end

    lbw_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (IW'(i_word.node_index)),
        .i_wdata (i_word.value),
        .i_raddr (node_raddr),
        .o_rdata (node_rd)
    );

    lbw_ram #(.WIDTH(Q_W), .DEPTH(MAX_NODES)) u_recip_ram (
        .i_clk   (i_clk),
        .i_we    (recip_we),
        .i_waddr (r_i[IW-1:0]),
        .i_wdata (recip_wdata),
        .i_raddr (r_i[IW-1:0]),
        .o_rdata (recip_rd)
    );

    always_comb begin
        case (r_state)
            S_RMUL:  mul_b = diff_sat(r_xi, node_rd);
            S_EMUL:  mul_b = diff_sat(r_pos, node_rd);
            default: mul_b = recip_rd;
        endcase
    end
    assign mul_en = (r_state == S_RMUL) || (r_state == S_EMUL) || (r_state == S_EWM);

    lbw_mul u_mul (
        .i_clk (i_clk),
        .i_en  (mul_en),
        .i_a   (r_acc),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign div_start = (r_state == S_RDIV) && (r_acc != '0);

    lbw_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_den   (r_acc),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_rvalid    = r_rvalid;
        n_zflag     = r_zflag;
        n_i         = r_i;
        n_j         = r_j;
        n_acc       = r_acc;
        n_xi        = r_xi;
        n_pos       = r_pos;
        n_weight    = r_weight;
        n_zd        = r_zd;
        recip_we    = 1'b0;
        recip_wdata = div_quot;
        case (r_state)
            S_IDLE: begin
                if (i_word.valid) begin
                    if (i_word.command == CMD_LOAD) begin
                        if (load_ok) begin
                            n_rvalid = 1'b0;
                        end
                    end else begin
                        n_pos   = i_word.value;
                        n_i     = '0;
                        n_state = r_rvalid ? S_ESTA : S_RADI;
                    end
                end
            end
            S_RADI: n_state = S_RXI;
            S_RXI: begin
                n_xi  = node_rd;
                n_acc = ONE_Q;
                n_j   = j_first;
                n_state = (j_first >= n_eff) ? S_RDIV : S_RMUL;
            end
            S_RMUL: n_state = S_RRND;
            S_RRND: begin
                n_acc = round_sat(mul_p);
                n_j   = j_next;
                n_state = (j_next >= n_eff) ? S_RDIV : S_RMUL;
            end
            S_RDIV, S_RWAIT: begin
                if ((r_state == S_RDIV && r_acc == '0)
                        || (r_state == S_RWAIT && div_done)) begin
                    recip_we = 1'b1;
                    n_zflag[r_i[IW-1:0]] = (r_state == S_RDIV);
                    recip_wdata = (r_state == S_RDIV) ? t_q'(0) : div_quot;
                    if (r_i + CW'(1) == n_eff) begin
                        n_i      = '0;
                        n_rvalid = 1'b1;
                        n_state  = S_ESTA;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_RADI;
                    end
                end else if (r_state == S_RDIV) begin
                    n_state = S_RWAIT;
                end
            end
            S_ESTA: begin
                n_acc = ONE_Q;
                n_j   = j_first;
                if (r_zflag[r_i[IW-1:0]]) begin
                    n_weight = '0;
                    n_zd     = 1'b1;
                    n_state  = S_EOUT;
                end else begin
                    n_zd    = 1'b0;
                    n_state = (j_first >= n_eff) ? S_ERCP : S_EMUL;
                end
            end
            S_EMUL: n_state = S_ERND;
            S_ERND: begin
                n_acc = round_sat(mul_p);
                n_j   = j_next;
                n_state = (j_next >= n_eff) ? S_ERCP : S_EMUL;
            end
            S_ERCP: n_state = S_EWM;
            S_EWM:  n_state = S_EWR;
            S_EWR: begin
                n_weight = round_sat(mul_p);
                n_state  = S_EOUT;
            end
            S_EOUT: begin
                if (o_word.ready) begin
                    if (r_i + CW'(1) == n_eff) begin
                        n_state = S_IDLE;
                    end else begin
                        n_i     = r_i + CW'(1);
                        n_state = S_ESTA;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cfg    <= CFG_W'(1);
            r_rvalid <= 1'b0;
            r_zflag  <= '0;
            r_i      <= '0;
        end else begin
            r_state  <= n_state;
            r_zflag  <= n_zflag;
            r_i      <= n_i;
            if (i_cfg_we) begin
                r_cfg    <= i_cfg_wdata;
                r_rvalid <= 1'b0;
            end else begin
                r_rvalid <= n_rvalid;
            end
        end
        r_j      <= n_j;
        r_acc    <= n_acc;
        r_xi     <= n_xi;
        r_pos    <= n_pos;
        r_weight <= n_weight;
        r_zd     <= n_zd;
    end

    assign i_word.ready            = (r_state == S_IDLE);
    assign o_word.valid            = (r_state == S_EOUT);
    assign o_word.weight           = r_weight;
    assign o_word.weight_index     = IDX_W'(r_i);
    assign o_word.last             = (r_i + CW'(1) == n_eff);
    assign o_word.zero_denominator = r_zd;

    a_zd_weight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid && o_word.zero_denominator |-> o_word.weight == '0)
        else $error("zero denominator with nonzero weight");

    a_eval_needs_recip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_ESTA |-> r_rvalid)
        else $error("evaluation without valid reciprocals");

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_start |-> r_acc != '0)
        else $error("divider started on zero");

    a_out_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid |-> r_i < n_eff)
        else $error("weight index beyond nodes in use");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_word.valid && !o_word.ready |=> o_word.valid && $stable(r_i))
        else $error("result dropped while stalled");

endmodule

// File: test/lbw_weight_checker.sv
// lbw_weight_checker: watches the input, result and register ports of the block,
// predicts every weight word in Q8.24 and compares each result field by field.
// Depends on lbw_pkg and lbw_if.
`timescale 1ns / 1ps

module lbw_weight_checker #(
    parameter int MAX_NODES = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    lbw_in_if                         word_in,
    lbw_out_if                        word_out,
    input  logic                      i_cfg_we,
    input  logic [lbw_pkg::CFG_W-1:0] i_cfg_wdata,
    output int                        o_fail_count,
    output int                        o_pending
);
    import lbw_pkg::*;

    typedef struct packed {
        t_q               weight;
        logic [IDX_W-1:0] index;
        logic             last;
        logic             zero_den;
    } t_weight_word;

    t_weight_word     expected_weights[$];
    t_q               node_x[MAX_NODES];
    t_q               recip[MAX_NODES];
    logic             den_zero[MAX_NODES];
    logic             recip_ok;
    logic [CFG_W-1:0] nodes_cfg;

    function automatic t_q clamp_q(input longint v);
        if (v > longint'(Q_MAX)) return Q_MAX;
        if (v < longint'(Q_MIN)) return Q_MIN;
        return t_q'(v);
    endfunction

    function automatic t_q q_sub(input t_q a, input t_q b);
        return clamp_q(longint'(a) - longint'(b));
    endfunction

    // round to nearest (ties up) by adding half an LSB, then floor shift
    function automatic t_q q_mul(input t_q a, input t_q b);
        longint p;
        p = longint'(a) * longint'(b) + (64'sd1 <<< 23);
        return clamp_q(p >>> 24);
    endfunction

    function automatic int active_nodes();
        if (nodes_cfg == 0) return 1;
        if (nodes_cfg > MAX_NODES) return MAX_NODES;
        return int'(nodes_cfg);
    endfunction

    task automatic rebuild_reciprocals(input int n);
        t_q d;
        for (int i = 0; i < n; i++) begin
            d = ONE_Q;
            for (int j = 0; j < n; j++)
                if (j != i) d = q_mul(d, q_sub(node_x[i], node_x[j]));
            den_zero[i] = (d == 0);
            // SV signed division truncates toward zero
            recip[i] = (d == 0) ? t_q'(0) : clamp_q((64'sd1 <<< 48) / longint'(d));
        end
        recip_ok = 1'b1;
    endtask

    task automatic predict_weights(input t_q pos);
        int n;
        t_q num;
        t_weight_word w;
        n = active_nodes();
        if (!recip_ok) rebuild_reciprocals(n);
        for (int i = 0; i < n; i++) begin
            w.weight = '0;
            if (!den_zero[i]) begin
                num = ONE_Q;
                for (int j = 0; j < n; j++)
                    if (j != i) num = q_mul(num, q_sub(pos, node_x[j]));
                w.weight = q_mul(num, recip[i]);
            end
            w.index    = IDX_W'(i);
            w.last     = (i == n - 1);
            w.zero_den = den_zero[i];
            expected_weights.push_back(w);
        end
    endtask

    assign o_pending = expected_weights.size();

    always @(posedge i_clk) begin
        t_weight_word exp_w;
        if (!i_rst_n) begin
            nodes_cfg = 1;
            recip_ok  = 1'b0;
            foreach (den_zero[k]) den_zero[k] = 1'b0;
            o_fail_count = 0;
            expected_weights.delete();
        end else begin
            if (i_cfg_we) begin
                nodes_cfg = i_cfg_wdata;
                recip_ok  = 1'b0;
            end
            if (word_in.valid && word_in.ready) begin
                if (word_in.command == CMD_LOAD) begin
                    if (int'(word_in.node_index) < MAX_NODES) begin
                        node_x[word_in.node_index] = word_in.value;
                        recip_ok = 1'b0;
                    end
                end else begin
                    predict_weights(word_in.value);
                end
            end
            if (word_out.valid && word_out.ready) begin
                if (expected_weights.size() == 0) begin
                    $error("unexpected weight word, index %0d", word_out.weight_index);
                    o_fail_count++;
                end else begin
                    exp_w = expected_weights.pop_front();
                    if (word_out.weight !== exp_w.weight) begin
                        $error("weight: expected %0d, got %0d", exp_w.weight, word_out.weight);
                        o_fail_count++;
                    end
                    if (word_out.weight_index !== exp_w.index) begin
                        $error("weight_index: expected %0d, got %0d",
                               exp_w.index, word_out.weight_index);
                        o_fail_count++;
                    end
                    if (word_out.last !== exp_w.last) begin
                        $error("last: expected %0b, got %0b", exp_w.last, word_out.last);
                        o_fail_count++;
                    end
                    if (word_out.zero_denominator !== exp_w.zero_den) begin
                        $error("zero_denominator: expected %0b, got %0b",
                               exp_w.zero_den, word_out.zero_denominator);
                        o_fail_count++;
                    end
                end
            end
        end
    end

endmodule

// File: test/testbench.sv
// testbench: stimulus and verdict for lagrange_basis_weights.
// Drives load / evaluate words and node-count writes; checking is done by
// lbw_weight_checker. Depends on lbw_pkg, lbw_if and the block's RTL.
`timescale 1ns / 1ps

module testbench;
    import lbw_pkg::*;

    localparam int NODES = 16;

    logic             i_clk;
    logic             i_rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    int               fail_count;
    int               pending;
    int               send_idle_pct;   // chance the sender skips a cycle
    int               recv_stall_pct;  // chance the receiver holds ready low
    int               item_count;
    t_q               node_shadow[NODES];  // last value loaded per slot

    lbw_in_if  in_word ();
    lbw_out_if out_word ();

    lagrange_basis_weights #(.MAX_NODES(NODES)) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (in_word),
        .o_word     (out_word),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata)
    );

    lbw_weight_checker #(.MAX_NODES(NODES)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .word_in     (in_word),
        .word_out    (out_word),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial i_clk = 1'b0;
    always #4 i_clk = ~i_clk;

    // receiver: ready changes only on the falling edge
    always @(negedge i_clk)
        out_word.ready = ($urandom_range(99) >= recv_stall_pct);

    // Q8.24 value mix: mostly small so weights stay in range, some full-range
    // words and the two rails
    function automatic t_q pick_value();
        case ($urandom_range(9))
            0:       return $urandom_range(1) ? Q_MAX : Q_MIN;
            1, 2:    return t_q'($urandom);
            default: return t_q'($urandom_range(32'h0FFF_FFFF)) - 32'sh0800_0000;
        endcase
    endfunction

    // one word on the input channel; valid stays high unless a gap is drawn
    task automatic send_word(input logic cmd, input logic [IDX_W-1:0] idx, input t_q val);
        while ($urandom_range(99) < send_idle_pct) begin
            in_word.valid = 1'b0;
            @(negedge i_clk);
        end
        in_word.valid      = 1'b1;
        in_word.command    = cmd;
        in_word.node_index = idx;
        in_word.value      = val;
        do @(posedge i_clk); while (!in_word.ready);
        @(negedge i_clk);
        if (cmd == CMD_LOAD) node_shadow[idx] = val;
        item_count++;
    endtask

    task automatic load_node(input int slot, input t_q val);
        send_word(CMD_LOAD, IDX_W'(slot), val);
    endtask

    task automatic evaluate(input t_q pos);
        send_word(CMD_EVAL, IDX_W'($urandom), pos);
    endtask

    // register writes only with the block idle: results drained, then a pause
    // long enough for any load still in flight
    task automatic write_nodes_in_use(input logic [CFG_W-1:0] n);
        in_word.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        cfg_we    = 1'b1;
        cfg_wdata = n;
        @(negedge i_clk);
        cfg_we = 1'b0;
    endtask

    initial begin
        int phase_items;
        in_word.valid      = 1'b0;
        in_word.command    = CMD_LOAD;
        in_word.node_index = '0;
        in_word.value      = '0;
        out_word.ready     = 1'b1;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        send_idle_pct      = 0;
        recv_stall_pct     = 0;
        item_count         = 0;
        i_rst_n            = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: single node at reset count, rails as node and position
        load_node(0, Q_MAX);
        evaluate(Q_MIN);
        load_node(0, Q_MIN);
        evaluate(Q_MAX);
        // fill every slot with distinct half-unit spaced nodes
        for (int s = 0; s < NODES; s++) load_node(s, t_q'((s - 8) * 32'sh0080_0000));
        write_nodes_in_use(5'd16);
        evaluate(32'sh0010_0000);
        evaluate(node_shadow[3]);           // position on a node
        // duplicate nodes give zero denominators
        write_nodes_in_use(5'd3);
        load_node(1, node_shadow[0]);
        evaluate(32'sh0100_0000);
        // nodes one LSB apart: denominator rounds to zero
        load_node(0, 32'sd0);
        load_node(1, 32'sd1);
        load_node(2, 32'sd2);
        evaluate(32'sd1);
        // zero acts as one node, above the maximum acts as the maximum
        write_nodes_in_use(5'd0);
        evaluate(Q_MAX);
        for (int s = 0; s < 3; s++) load_node(s, t_q'((s - 8) * 32'sh0080_0000));
        write_nodes_in_use(5'd31);
        evaluate(32'sh0040_0000);

        // random: four idling phases, well-formed load/evaluate runs
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 53; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 53; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            phase_items = 0;
            while (phase_items < 40) begin
                // mostly small node counts; now and then 0, the maximum or above
                case ($urandom_range(9))
                    0:       write_nodes_in_use(CFG_W'($urandom_range(31)));
                    1:       write_nodes_in_use(5'd16);
                    default: write_nodes_in_use(CFG_W'($urandom_range(1, 5)));
                endcase
                repeat ($urandom_range(1, 3)) begin
                    repeat ($urandom_range(0, 3)) begin
                        if ($urandom_range(7) == 0)
                            load_node($urandom_range(NODES - 1),
                                      node_shadow[$urandom_range(NODES - 1)]);
                        else
                            load_node($urandom_range(NODES - 1), pick_value());
                        phase_items++;
                    end
                    repeat ($urandom_range(1, 3)) begin
                        if ($urandom_range(4) == 0)
                            evaluate(node_shadow[$urandom_range(NODES - 1)]);
                        else
                            evaluate(pick_value());
                        phase_items++;
                    end
                end
            end
        end

        in_word.valid = 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (50) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #50ms;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
